### src/btd_pkg.sv
// Shared types and constants for the BER-TLV stream deframer.
`default_nettype none
package btd_pkg;

  localparam int MAX_TAG_BYTES = 4;
  localparam int COUNT_WIDTH   = 16;

  localparam int TAG_CNT_W = ($clog2(MAX_TAG_BYTES + 1) > 3) ? $clog2(MAX_TAG_BYTES + 1) : 3;

  localparam logic [15:0] COUNT_LIMIT =
    (COUNT_WIDTH >= 16) ? 16'hFFFF : 16'((32'd1 << COUNT_WIDTH) - 32'd1);

  localparam logic [2:0] LEN_BYTES_MAX = 3'd4;

  localparam logic [7:0] TAG_CONSTRUCTED = 8'h20;
  localparam logic [7:0] TAG_NUMBER_MASK = 8'h1F;
  localparam logic [7:0] LEN_LONG_FORM   = 8'h80;
  localparam logic [7:0] LEN_COUNT_MASK  = 8'h7F;

  typedef enum logic [1:0] {
    CLASS_TAG   = 2'd0,
    CLASS_LEN   = 2'd1,
    CLASS_VALUE = 2'd2,
    CLASS_DROP  = 2'd3
  } btd_class_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_TAG_LONG = 2'd1,
    ERR_LEN_LONG = 2'd2,
    ERR_EOB      = 2'd3
  } btd_err_t;

  typedef struct packed {
    btd_class_t  byte_class;
    logic [7:0]  byte_out;
    logic [31:0] tag_value;
    logic [2:0]  tag_bytes;
    logic        constructed;
    logic [31:0] value_length;
    logic [31:0] value_offset;
    logic        item_end;
    logic [15:0] item_count;
    btd_err_t    error_code;
  } btd_result_t;

endpackage
`default_nettype wire

### src/btd_if.sv
// Handshake channel interfaces for the deframer: byte input, result output, config write.
`default_nettype none
interface btd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;
  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
  modport mon    (input valid, input data_byte, input end_of_buffer, input ready);
endinterface

interface btd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  byte_class;
  logic [7:0]  byte_out;
  logic [31:0] tag_value;
  logic [2:0]  tag_bytes;
  logic        constructed;
  logic [31:0] value_length;
  logic [31:0] value_offset;
  logic        item_end;
  logic [15:0] item_count;
  logic [1:0]  error_code;
  modport source (output valid, output byte_class, output byte_out, output tag_value,
                  output tag_bytes, output constructed, output value_length,
                  output value_offset, output item_end, output item_count,
                  output error_code, input ready);
  modport sink   (input valid, input byte_class, input byte_out, input tag_value,
                  input tag_bytes, input constructed, input value_length,
                  input value_offset, input item_end, input item_count,
                  input error_code, output ready);
  modport mon    (input valid, input byte_class, input byte_out, input tag_value,
                  input tag_bytes, input constructed, input value_length,
                  input value_offset, input item_end, input item_count,
                  input error_code, input ready);
endinterface

interface btd_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] max_length_bytes;
  modport source (output valid, output max_length_bytes, input ready);
  modport sink   (input valid, input max_length_bytes, output ready);
  modport mon    (input valid, input max_length_bytes, input ready);
endinterface
`default_nettype wire

### src/ber_tlv_stream_deframer.sv
// A result is registered and valid in the cycle after its byte transaction, when the output is free.
// Throughput: one byte per cycle while the skid entry is empty; the per-byte parser state update sets that figure.
// A skid entry behind the result register takes the byte accepted during an output stall;
// input then pauses until that entry moves up into the result register once the stall clears.
// Reset (rst, synchronous, active high) returns the parser to the tag phase, clears
// the counters and both output entries, and sets max_length_bytes to 4.
`default_nettype none
module ber_tlv_stream_deframer (
  input  wire logic  clk,
  input  wire logic  rst,
  btd_in_if.sink     stream,
  btd_out_if.source  result,
  btd_cfg_if.sink    cfg
);
  import btd_pkg::*;

  typedef enum logic [2:0] {
    PH_TAG_FIRST,
    PH_TAG_MORE,
    PH_LEN_FIRST,
    PH_LEN_MORE,
    PH_VALUE,
    PH_DROP
  } phase_t;

  phase_t               phase, phase_next;
  logic [31:0]          tag_accum, tag_accum_next;
  logic [TAG_CNT_W-1:0] tag_count, tag_count_next;
  logic                 constructed_bit, constructed_bit_next;
  logic [31:0]          length_accum, length_accum_next;
  logic [2:0]           length_bytes_left, length_bytes_left_next;
  logic [31:0]          value_position, value_position_next;
  logic [15:0]          items_done, items_done_next;
  logic [2:0]           max_length_bytes;

  btd_result_t res;
  btd_result_t out_reg, skid_reg;
  logic        out_valid, skid_valid;
  logic        in_fire, out_free;

  assign cfg.ready    = 1'b1;
  assign stream.ready = !skid_valid;
  assign in_fire      = stream.valid && stream.ready;
  assign out_free     = !out_valid || result.ready;

  always_comb begin
    logic [7:0]  b;
    logic [2:0]  maxlen;
    btd_class_t  cls;
    btd_err_t    err;
    logic        end_flag;
    logic        dropped;
    logic [31:0] offset;
    logic [31:0] pos_inc;

    b        = stream.data_byte;
    maxlen   = (max_length_bytes > LEN_BYTES_MAX) ? LEN_BYTES_MAX : max_length_bytes;
    cls      = CLASS_DROP;
    err      = ERR_NONE;
    end_flag = 1'b0;
    dropped  = 1'b0;
    offset   = 32'd0;
    pos_inc  = value_position + 32'd1;

    phase_next             = phase;
    tag_accum_next         = tag_accum;
    tag_count_next         = tag_count;
    constructed_bit_next   = constructed_bit;
    length_accum_next      = length_accum;
    length_bytes_left_next = length_bytes_left;
    value_position_next    = value_position;
    items_done_next        = items_done;

    unique case (phase)
      PH_TAG_FIRST: begin
        cls                    = CLASS_TAG;
        tag_accum_next         = {24'd0, b};
        tag_count_next         = TAG_CNT_W'(1);
        constructed_bit_next   = (b & TAG_CONSTRUCTED) != 8'd0;
        length_accum_next      = 32'd0;
        length_bytes_left_next = 3'd0;
        value_position_next    = 32'd0;
        phase_next = ((b & TAG_NUMBER_MASK) == TAG_NUMBER_MASK) ? PH_TAG_MORE : PH_LEN_FIRST;
      end
      PH_TAG_MORE: begin
        if (tag_count >= TAG_CNT_W'(MAX_TAG_BYTES)) begin
          err        = ERR_TAG_LONG;
          dropped    = 1'b1;
          phase_next = PH_DROP;
        end else begin
          cls            = CLASS_TAG;
          tag_accum_next = {tag_accum[23:0], b};
          tag_count_next = tag_count + TAG_CNT_W'(1);
          if (!b[7]) phase_next = PH_LEN_FIRST;
        end
      end
      PH_LEN_FIRST: begin
        cls = CLASS_LEN;
        if (!b[7]) begin
          length_accum_next = {24'd0, b};
          if (b == 8'd0) begin
            end_flag   = 1'b1;
            phase_next = PH_TAG_FIRST;
          end else begin
            phase_next = PH_VALUE;
          end
        end else if (b == LEN_LONG_FORM) begin
          length_accum_next = 32'd0;
          end_flag          = 1'b1;
          phase_next        = PH_TAG_FIRST;
        end else if ((b & LEN_COUNT_MASK) > {5'd0, maxlen}) begin
          cls        = CLASS_DROP;
          err        = ERR_LEN_LONG;
          dropped    = 1'b1;
          phase_next = PH_DROP;
        end else begin
          // count is at most four here, so the low three bits hold it
          length_accum_next      = 32'd0;
          length_bytes_left_next = b[2:0];
          phase_next             = PH_LEN_MORE;
        end
      end
      PH_LEN_MORE: begin
        cls               = CLASS_LEN;
        length_accum_next = {length_accum[23:0], b};
        if (length_bytes_left != 3'd0) length_bytes_left_next = length_bytes_left - 3'd1;
        if (length_bytes_left_next == 3'd0) begin
          if (length_accum_next == 32'd0) begin
            end_flag   = 1'b1;
            phase_next = PH_TAG_FIRST;
          end else begin
            phase_next = PH_VALUE;
          end
        end
      end
      PH_VALUE: begin
        cls                 = CLASS_VALUE;
        offset              = value_position;
        value_position_next = pos_inc;
        if (pos_inc >= length_accum) begin
          end_flag   = 1'b1;
          phase_next = PH_TAG_FIRST;
        end
      end
      default: begin
        cls        = CLASS_DROP;
        dropped    = 1'b1;
        phase_next = PH_DROP;
      end
    endcase

    if (end_flag && items_done < COUNT_LIMIT) items_done_next = items_done + 16'd1;

    // flag a buffer that stops inside an item, unless this byte already failed
    if (stream.end_of_buffer && err == ERR_NONE && !dropped && phase_next != PH_TAG_FIRST) begin
      err = ERR_EOB;
    end

    res.byte_class = cls;
    res.byte_out   = b;
    if (dropped) begin
      res.tag_value    = 32'd0;
      res.tag_bytes    = 3'd0;
      res.constructed  = 1'b0;
      res.value_length = 32'd0;
      res.value_offset = 32'd0;
    end else begin
      res.tag_value    = tag_accum_next;
      res.tag_bytes    = (tag_count_next > TAG_CNT_W'(7)) ? 3'd7 : tag_count_next[2:0];
      res.constructed  = constructed_bit_next;
      res.value_length = (cls == CLASS_TAG) ? 32'd0 : length_accum_next;
      res.value_offset = offset;
    end
    res.item_end   = end_flag;
    res.item_count = items_done_next;
    res.error_code = err;

    if (stream.end_of_buffer) begin
      phase_next             = PH_TAG_FIRST;
      length_bytes_left_next = 3'd0;
      value_position_next    = 32'd0;
      items_done_next        = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_TAG_FIRST;
      tag_accum         <= 32'd0;
      tag_count         <= '0;
      constructed_bit   <= 1'b0;
      length_accum      <= 32'd0;
      length_bytes_left <= 3'd0;
      value_position    <= 32'd0;
      items_done        <= 16'd0;
      max_length_bytes  <= LEN_BYTES_MAX;
      out_valid         <= 1'b0;
      skid_valid        <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) max_length_bytes <= cfg.max_length_bytes;
      if (in_fire) begin
        phase             <= phase_next;
        tag_accum         <= tag_accum_next;
        tag_count         <= tag_count_next;
        constructed_bit   <= constructed_bit_next;
        length_accum      <= length_accum_next;
        length_bytes_left <= length_bytes_left_next;
        value_position    <= value_position_next;
        items_done        <= items_done_next;
      end
      // skid is empty whenever a byte transaction happens
      if (in_fire) begin
        if (out_free) begin
          out_reg   <= res;
          out_valid <= 1'b1;
        end else begin
          skid_reg   <= res;
          skid_valid <= 1'b1;
        end
      end else if (out_free) begin
        out_reg    <= skid_reg;
        out_valid  <= skid_valid;
        skid_valid <= 1'b0;
      end
    end
  end

  assign result.valid        = out_valid;
  assign result.byte_class   = out_reg.byte_class;
  assign result.byte_out     = out_reg.byte_out;
  assign result.tag_value    = out_reg.tag_value;
  assign result.tag_bytes    = out_reg.tag_bytes;
  assign result.constructed  = out_reg.constructed;
  assign result.value_length = out_reg.value_length;
  assign result.value_offset = out_reg.value_offset;
  assign result.item_end     = out_reg.item_end;
  assign result.item_count   = out_reg.item_count;
  assign result.error_code   = out_reg.error_code;

endmodule
`default_nettype wire

### src/btd_checker.sv
// Port-level checks for the deframer, bound to the top level.
`default_nettype none
module btd_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [1:0]  byte_class,
  input  wire logic [7:0]  byte_out,
  input  wire logic [31:0] tag_value,
  input  wire logic [31:0] value_length,
  input  wire logic [31:0] value_offset,
  input  wire logic        item_end,
  input  wire logic [15:0] item_count,
  input  wire logic [1:0]  error_code
);
  import btd_pkg::*;

  // hold a stalled result transaction
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(byte_out)
      && $stable(item_count) && $stable(byte_class))
    else $error("stalled result changed");

  // a byte taken while the output is free shows up the next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (out_ready || !out_valid) |=> out_valid)
    else $error("result missing one cycle after byte transaction");

  a_end_class: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_end |->
      byte_class == CLASS_LEN || byte_class == CLASS_VALUE)
    else $error("item end on a tag or dropped byte");

  a_drop_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_class == CLASS_DROP |->
      tag_value == 32'd0 && value_length == 32'd0
      && value_offset == 32'd0 && error_code != ERR_EOB)
    else $error("dropped byte carries item fields");

endmodule

bind ber_tlv_stream_deframer btd_checker u_btd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (stream.valid),
  .in_ready     (stream.ready),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .byte_class   (result.byte_class),
  .byte_out     (result.byte_out),
  .tag_value    (result.tag_value),
  .value_length (result.value_length),
  .value_offset (result.value_offset),
  .item_end     (result.item_end),
  .item_count   (result.item_count),
  .error_code   (result.error_code)
);
`default_nettype wire
